@@ src/stp_pkg.sv @@
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, constants and helpers of the stepper position PID loop.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  // parameter defaults
  localparam int unsigned COUNTS_PER_REV_DEF     = 16384;
  localparam int unsigned INTEGRAL_LIMIT_DEF     = 8192;
  localparam int unsigned FULL_STEPS_PER_REV_DEF = 200;

  // scale numerator: 8192 / microstep divisor
  localparam int unsigned SCALE_W   = 14;
  localparam logic [SCALE_W-1:0] SCALE_NUM = 14'd8192;
  localparam int unsigned UDIV_W    = 9;

  // floor(n / 100) == (n * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit n
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int unsigned DIV100_SHIFT = 37;

  localparam logic [31:0] VC_GAIN = 32'd13;

  typedef enum logic [2:0] {
    CFG_STEP_OFFSET   = 3'd0,
    CFG_MICROSTEP_DIV = 3'd1,
    CFG_GAIN_P        = 3'd2,
    CFG_GAIN_I        = 3'd3,
    CFG_GAIN_D        = 3'd4,
    CFG_FILTER_A      = 3'd5,
    CFG_FILTER_B      = 3'd6,
    CFG_CURRENT_LIMIT = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UNWRAP,
    S_M_POS,
    S_M_FA,
    S_M_FB,
    S_M_FD,
    S_DFILT,
    S_M_SC,
    S_M_REC,
    S_TARGET,
    S_ERR,
    S_M_I,
    S_M_P,
    S_SUM,
    S_M_V,
    S_OUT
  } seq_state_e;

  // request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // signed divide by 2^sh, truncating toward zero
  function automatic logic [31:0] sdiv_pow2(logic [31:0] x, logic [4:0] sh);
    logic [31:0]        bias;
    logic signed [31:0] t;
    bias = x[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
    t    = signed'(x + bias);
    return 32'(t >>> sh);
  endfunction

endpackage

`default_nettype wire

@@ src/stp_in_if.sv @@
// ----------------------------------------------------------------------------
// stp_in_if
// Input channel: encoder angle and step count per control tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_in_if;
  logic               valid;
  logic               ready;
  logic [13:0]        encoder_angle;
  logic signed [31:0] step_count;

  modport source (output valid, output encoder_angle, output step_count, input ready);
  modport sink   (input valid, input encoder_angle, input step_count, output ready);
endinterface

`default_nettype wire

@@ src/stp_out_if.sv @@
// ----------------------------------------------------------------------------
// stp_out_if
// Output channel: phase angle, current magnitude and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] phase_angle;
  logic [11:0]        current_ma;
  logic               error_clamped;
  logic               revolution_crossed;

  modport source (output valid, output phase_angle, output current_ma,
                  output error_clamped, output revolution_crossed, input ready);
  modport sink   (input valid, input phase_angle, input current_ma,
                  input error_clamped, input revolution_crossed, output ready);
endinterface

`default_nettype wire

@@ src/stp_mul.sv @@
// ----------------------------------------------------------------------------
// stp_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_mul (
  input  wire logic              clk_i,
  input  wire stp_pkg::mul_req_t req_i,
  output      logic [63:0]       prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= {32'd0, req_i.a} * {32'd0, req_i.b};
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ src/stp_sdiv.sv @@
// ----------------------------------------------------------------------------
// stp_sdiv
// Radix-2 restoring divider: 8192 / microstep divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_sdiv (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [stp_pkg::UDIV_W-1:0]   divisor_i,
  output      logic                         busy_o,
  output      logic [stp_pkg::SCALE_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(stp_pkg::SCALE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(stp_pkg::SCALE_W - 1);

  logic                         busy_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [stp_pkg::UDIV_W-1:0]   den_q;
  logic [stp_pkg::UDIV_W-1:0]   rem_q;
  logic [stp_pkg::SCALE_W-1:0]  quot_q;
  logic [stp_pkg::UDIV_W:0]     rem_sh;
  logic                         fits;

  assign rem_sh = {rem_q, quot_q[stp_pkg::SCALE_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_LAST;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // a zero divisor counts as one
      den_q  <= (divisor_i == '0) ? stp_pkg::UDIV_W'(1) : divisor_i;
      rem_q  <= '0;
      quot_q <= stp_pkg::SCALE_NUM;
    end else if (busy_q) begin
      rem_q  <= fits ? stp_pkg::UDIV_W'(rem_sh - {1'b0, den_q})
                     : rem_sh[stp_pkg::UDIV_W-1:0];
      quot_q <= {quot_q[stp_pkg::SCALE_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ src/stepper_position_pid_loop_core.sv @@
// ----------------------------------------------------------------------------
// stepper_position_pid_loop_core
// Closed-loop stepper position PID: target from step count, multi-turn
// encoder unwrap, clamped error, PID with filtered derivative, phase/current.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        encoder_angle, step_count
//   out_ch    out  valid/ready        phase_angle, current_ma, flags
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One item at a time: the sequencer runs alongside the serial divide of the
// microstep scale and waits for it before 8 further steps (5 of them shared
// 32x32 multiplier passes) and the output load. in_ch.ready is high only when
// the sequencer idles. A finished result sits in the output register; the next
// item is taken while it waits, and the sequencer holds in its last step until
// it is free. Async reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_position_pid_loop_core #(
  parameter int unsigned COUNTS_PER_REV     = stp_pkg::COUNTS_PER_REV_DEF,
  parameter int unsigned INTEGRAL_LIMIT     = stp_pkg::INTEGRAL_LIMIT_DEF,
  parameter int unsigned FULL_STEPS_PER_REV = stp_pkg::FULL_STEPS_PER_REV_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  stp_in_if.sink           in_ch,
  stp_out_if.source        out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam logic [31:0] CPR       = 32'(COUNTS_PER_REV);
  localparam logic [31:0] HALF      = 32'(COUNTS_PER_REV / 2);
  localparam logic [31:0] ELIM      = 32'(COUNTS_PER_REV / 10);
  localparam logic [31:0] ILIM      = 32'(INTEGRAL_LIMIT);
  localparam logic [31:0] FULLSTEP  = 32'(COUNTS_PER_REV / FULL_STEPS_PER_REV);
  localparam logic [31:0] NEG_HALF  = 32'd0 - HALF;
  localparam logic [31:0] NEG_ELIM  = 32'd0 - ELIM;
  localparam logic [31:0] NEG_ILIM  = 32'd0 - ILIM;
  localparam int unsigned Q100_W    = 64 - stp_pkg::DIV100_SHIFT;

  // configuration
  logic [31:0]                offset_q;
  logic [stp_pkg::UDIV_W-1:0] udiv_q;
  logic [11:0]                kp_q, ki_q, kd_q, cur_lim_q;
  logic [7:0]                 fa_q, fb_q;

  // loop state
  logic [13:0] prev_ang_q;
  logic [31:0] rev_q, prev_pos_q, integ_q, dfilt_q;

  // per-item working registers
  logic [13:0] enc_q;
  logic [31:0] steps_q, pos_q, delta_q, ta_q, target_q, err_q, v_q;
  logic        crossed_q, neg_q, clamped_q;

  // output register
  logic        out_v_q;
  logic [31:0] out_phase_q;
  logic [11:0] out_cur_q;
  logic        out_clamp_q, out_cross_q;

  stp_pkg::seq_state_e state_q, state_d;
  stp_pkg::mul_req_t   mreq;
  logic [63:0]         prod;
  logic [31:0]         p32;
  logic                div_busy;
  logic [stp_pkg::SCALE_W-1:0] scale;
  logic                in_xfer, out_free;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_q || out_ch.ready;
  assign p32      = prod[31:0];

  stp_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  stp_sdiv u_sdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_xfer),
    .divisor_i (udiv_q),
    .busy_o    (div_busy),
    .quot_o    (scale)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      udiv_q    <= stp_pkg::UDIV_W'(16);
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      fa_q      <= '0;
      fb_q      <= '0;
      cur_lim_q <= 12'd3300;
    end else if (cfg_we_i) begin
      case (stp_pkg::cfg_idx_e'(cfg_idx_i))
        stp_pkg::CFG_STEP_OFFSET:   offset_q  <= cfg_wdata_i;
        stp_pkg::CFG_MICROSTEP_DIV: udiv_q    <= cfg_wdata_i[stp_pkg::UDIV_W-1:0];
        stp_pkg::CFG_GAIN_P:        kp_q      <= cfg_wdata_i[11:0];
        stp_pkg::CFG_GAIN_I:        ki_q      <= cfg_wdata_i[11:0];
        stp_pkg::CFG_GAIN_D:        kd_q      <= cfg_wdata_i[11:0];
        stp_pkg::CFG_FILTER_A:      fa_q      <= cfg_wdata_i[7:0];
        stp_pkg::CFG_FILTER_B:      fb_q      <= cfg_wdata_i[7:0];
        stp_pkg::CFG_CURRENT_LIMIT: cur_lim_q <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      stp_pkg::S_IDLE:   if (in_xfer) state_d = stp_pkg::S_UNWRAP;
      stp_pkg::S_UNWRAP: state_d = stp_pkg::S_M_POS;
      stp_pkg::S_M_POS:  state_d = stp_pkg::S_M_FA;
      stp_pkg::S_M_FA:   state_d = stp_pkg::S_M_FB;
      stp_pkg::S_M_FB:   state_d = stp_pkg::S_M_FD;
      stp_pkg::S_M_FD:   state_d = stp_pkg::S_DFILT;
      stp_pkg::S_DFILT:  state_d = stp_pkg::S_M_SC;
      stp_pkg::S_M_SC:   if (!div_busy) state_d = stp_pkg::S_M_REC;
      stp_pkg::S_M_REC:  state_d = stp_pkg::S_TARGET;
      stp_pkg::S_TARGET: state_d = stp_pkg::S_ERR;
      stp_pkg::S_ERR:    state_d = stp_pkg::S_M_I;
      stp_pkg::S_M_I:    state_d = stp_pkg::S_M_P;
      stp_pkg::S_M_P:    state_d = stp_pkg::S_SUM;
      stp_pkg::S_SUM:    state_d = stp_pkg::S_M_V;
      stp_pkg::S_M_V:    state_d = stp_pkg::S_OUT;
      stp_pkg::S_OUT:    if (out_free) state_d = stp_pkg::S_IDLE;
      default:           state_d = stp_pkg::S_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mreq = '0;
    case (state_q)
      stp_pkg::S_M_POS: begin
        mreq = '{en: 1'b1, a: CPR, b: rev_q};
      end
      stp_pkg::S_M_FA: begin
        mreq = '{en: 1'b1, a: {24'd0, fa_q}, b: dfilt_q};
      end
      stp_pkg::S_M_FB: begin
        mreq = '{en: 1'b1, a: {24'd0, fb_q}, b: {20'd0, kd_q}};
      end
      stp_pkg::S_M_FD: begin
        mreq = '{en: 1'b1, a: p32, b: delta_q};
      end
      stp_pkg::S_M_SC: begin
        mreq = '{en: !div_busy, a: {18'd0, scale}, b: steps_q};
      end
      stp_pkg::S_M_REC: begin
        // magnitude of the scaled count; sign restored after the divide
        mreq = '{en: 1'b1, a: (p32[31] ? 32'd0 - p32 : p32), b: stp_pkg::DIV100_MAGIC};
      end
      stp_pkg::S_M_I: begin
        mreq = '{en: 1'b1, a: {20'd0, ki_q}, b: err_q};
      end
      stp_pkg::S_M_P: begin
        mreq = '{en: 1'b1, a: {20'd0, kp_q}, b: err_q};
      end
      stp_pkg::S_M_V: begin
        mreq = '{en: 1'b1, a: v_q, b: stp_pkg::VC_GAIN};
      end
      default: mreq = '0;
    endcase
  end

  // ---------------- datapath ----------------
  logic [31:0] jump, pos_n, e_raw, isum, q100, q100_s, vsum;
  logic [31:0] theta, mag, vc;

  assign jump   = {18'd0, enc_q} - {18'd0, prev_ang_q};
  assign pos_n  = {18'd0, enc_q} + p32;
  assign e_raw  = target_q - pos_q;
  assign isum   = integ_q + stp_pkg::sdiv_pow2(p32, 5'd5);
  assign q100   = {{(32 - Q100_W){1'b0}}, prod[63:stp_pkg::DIV100_SHIFT]};
  assign q100_s = neg_q ? 32'd0 - q100 : q100;
  assign vsum   = p32 + integ_q + dfilt_q;
  assign vc     = p32;

  always_comb begin
    if ($signed(vc) > 0) begin
      theta = {18'd0, enc_q} + FULLSTEP + delta_q;
      mag   = vc;
    end else if ($signed(vc) < 0) begin
      theta = {18'd0, enc_q} - FULLSTEP + delta_q;
      mag   = 32'd0 - vc;
    end else begin
      theta = {18'd0, enc_q};
      mag   = '0;
    end
  end

  // loop state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ang_q <= '0;
      rev_q      <= '0;
      prev_pos_q <= '0;
      integ_q    <= '0;
      dfilt_q    <= '0;
    end else begin
      case (state_q)
        stp_pkg::S_UNWRAP: begin
          prev_ang_q <= enc_q;
          if ($signed(jump) > $signed(HALF)) begin
            rev_q <= rev_q - 32'd1;
          end else if ($signed(jump) < $signed(NEG_HALF)) begin
            rev_q <= rev_q + 32'd1;
          end
        end
        stp_pkg::S_M_FA: prev_pos_q <= pos_n;
        stp_pkg::S_DFILT: dfilt_q <= ta_q - stp_pkg::sdiv_pow2(p32, 5'd3);
        stp_pkg::S_M_P: begin
          if ($signed(isum) > $signed(ILIM)) begin
            integ_q <= ILIM;
          end else if ($signed(isum) < $signed(NEG_ILIM)) begin
            integ_q <= NEG_ILIM;
          end else begin
            integ_q <= isum;
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      stp_pkg::S_IDLE: begin
        if (in_xfer) begin
          enc_q   <= in_ch.encoder_angle;
          steps_q <= in_ch.step_count;
        end
      end
      stp_pkg::S_UNWRAP: begin
        crossed_q <= ($signed(jump) > $signed(HALF)) || ($signed(jump) < $signed(NEG_HALF));
      end
      stp_pkg::S_M_FA: begin
        pos_q   <= pos_n;
        delta_q <= pos_n - prev_pos_q;
      end
      stp_pkg::S_M_FB:   ta_q  <= stp_pkg::sdiv_pow2(p32, 5'd7);
      stp_pkg::S_M_REC:  neg_q <= p32[31];
      stp_pkg::S_TARGET: target_q <= offset_q + q100_s;
      stp_pkg::S_ERR: begin
        if ($signed(e_raw) > $signed(ELIM)) begin
          err_q     <= ELIM;
          clamped_q <= 1'b1;
        end else if ($signed(e_raw) < $signed(NEG_ELIM)) begin
          err_q     <= NEG_ELIM;
          clamped_q <= 1'b1;
        end else begin
          err_q     <= e_raw;
          clamped_q <= 1'b0;
        end
      end
      stp_pkg::S_SUM: v_q <= stp_pkg::sdiv_pow2(vsum, 5'd7);
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic out_load;
  assign out_load = (state_q == stp_pkg::S_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_phase_q <= theta;
      out_clamp_q <= clamped_q;
      out_cross_q <= crossed_q;
      if ($signed(mag) > $signed({20'd0, cur_lim_q})) begin
        out_cur_q <= cur_lim_q;
      end else if (mag[31]) begin
        out_cur_q <= '0;
      end else begin
        out_cur_q <= mag[11:0];
      end
    end
  end

  assign in_ch.ready               = (state_q == stp_pkg::S_IDLE);
  assign out_ch.valid              = out_v_q;
  assign out_ch.phase_angle        = out_phase_q;
  assign out_ch.current_ma         = out_cur_q;
  assign out_ch.error_clamped      = out_clamp_q;
  assign out_ch.revolution_crossed = out_cross_q;

  // ---------------- assertions ----------------
  a_div_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> div_busy && (state_q == stp_pkg::S_UNWRAP))
    else $error("scale divide not running after item transfer");

  a_integ_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(integ_q) <= $signed(ILIM)) && ($signed(integ_q) >= $signed(NEG_ILIM)))
    else $error("integral outside its limit");

  a_err_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stp_pkg::S_M_I) |->
      (($signed(err_q) <= $signed(ELIM)) && ($signed(err_q) >= $signed(NEG_ELIM))))
    else $error("error outside clamp");

  a_sc_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stp_pkg::S_M_REC) |-> !$past(div_busy))
    else $error("scale used before divide finished");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_v_q || out_ch.ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

@@ sim/tb_stepper_position_pid_loop_core.sv @@
// ----------------------------------------------------------------------------
// tb_stepper_position_pid_loop_core
// Self-checking bench for the closed-loop stepper PID core. Control ticks go in
// through a valid/ready driver, results come back through a monitor and are
// checked field by field against a cycle-free loop predictor. The bench runs a
// short directed set, then register phases of encoder-tracking motion with
// glitches, plus noise phases, with random stalls on both sides in most phases.
// ----------------------------------------------------------------------------
module tb_stepper_position_pid_loop_core;
  timeunit 1ns;
  timeprecision 1ps;

  import stp_pkg::*;

  localparam int REV_COUNTS   = int'(COUNTS_PER_REV_DEF);
  localparam int HALF_REV     = REV_COUNTS / 2;
  localparam int ERR_LIMIT    = REV_COUNTS / 10;
  localparam int INTEG_LIMIT  = int'(INTEGRAL_LIMIT_DEF);
  localparam int FULL_STEP    = REV_COUNTS / int'(FULL_STEPS_PER_REV_DEF);
  localparam int PHASE_TICKS  = 195;
  localparam int NUM_PHASES   = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 50;
  localparam int LIMIT_CYCLES = 600000;

  typedef enum {SET_HIGH, SET_LOW, SET_MIXED} set_mode_e;

  typedef struct packed {
    logic [13:0]        angle;
    logic signed [31:0] steps;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] phase;
    logic [11:0]        cur;
    logic               clamped;
    logic               crossed;
  } drive_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  stp_in_if  in_ch ();
  stp_out_if out_ch ();

  stepper_position_pid_loop_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register shadow and loop state of the predictor
  logic [31:0] reg_shadow [8];
  logic [31:0] next_set [8];
  logic [13:0] prev_angle;
  logic [31:0] rev_cnt, prev_pos, integ, dfilt;

  tick_t  tick_q [$];
  drive_t predicted_drive_q [$];

  logic tick_offered = 1'b0;
  logic idle_en = 1'b1;
  logic hold_out_req = 1'b0;
  int   errors = 0;
  int   ticks_done = 0;
  int   results_seen = 0;
  int   n_crossed = 0;
  int   n_clamped = 0;
  int   cycles = 0;

  function automatic logic [31:0] trunc_div(logic [31:0] a, int d);
    int sa;
    sa = a;
    return 32'(sa / d);
  endfunction

  function automatic logic [31:0] commanded_pos(logic [31:0] off, logic [8:0] div,
                                                logic [31:0] steps);
    logic [31:0] d;
    d = (div == 9'd0) ? 32'd1 : {23'd0, div};
    return off + trunc_div((32'd8192 / d) * steps, 100);
  endfunction

  // one control tick of the loop; updates the predictor state
  function automatic drive_t advance_loop(tick_t t);
    logic [31:0] enc, pos, err, delta, vc, theta;
    logic [31:0] gp, gi, gd, fa, fb, lim;
    int jump, serr, si, svc;
    drive_t r;
    gp  = {20'd0, reg_shadow[CFG_GAIN_P][11:0]};
    gi  = {20'd0, reg_shadow[CFG_GAIN_I][11:0]};
    gd  = {20'd0, reg_shadow[CFG_GAIN_D][11:0]};
    fa  = {24'd0, reg_shadow[CFG_FILTER_A][7:0]};
    fb  = {24'd0, reg_shadow[CFG_FILTER_B][7:0]};
    lim = {20'd0, reg_shadow[CFG_CURRENT_LIMIT][11:0]};
    enc = {18'd0, t.angle};
    r.clamped = 1'b0;
    r.crossed = 1'b0;

    jump = int'(enc) - int'({18'd0, prev_angle});
    if (jump > HALF_REV) begin
      rev_cnt = rev_cnt - 32'd1;
      r.crossed = 1'b1;
    end else if (jump < -HALF_REV) begin
      rev_cnt = rev_cnt + 32'd1;
      r.crossed = 1'b1;
    end
    pos = enc + 32'(REV_COUNTS) * rev_cnt;

    err = commanded_pos(reg_shadow[CFG_STEP_OFFSET], reg_shadow[CFG_MICROSTEP_DIV][8:0],
                        t.steps) - pos;
    serr = err;
    if (serr > ERR_LIMIT) begin
      err = ERR_LIMIT;
      r.clamped = 1'b1;
    end else if (serr < -ERR_LIMIT) begin
      err = -ERR_LIMIT;
      r.clamped = 1'b1;
    end

    integ = integ + trunc_div(gi * err, 32);
    si = integ;
    if (si > INTEG_LIMIT) integ = INTEG_LIMIT;
    else if (si < -INTEG_LIMIT) integ = -INTEG_LIMIT;

    delta = pos - prev_pos;
    dfilt = trunc_div(fa * dfilt, 128) - trunc_div(fb * gd * delta, 8);
    vc = trunc_div(gp * err + integ + dfilt, 128) * 32'd13;

    prev_angle = t.angle;
    prev_pos   = pos;

    // lead or lag the rotor by one full step plus velocity feed-forward
    theta = enc;
    svc = vc;
    if (svc > 0) begin
      theta = theta + 32'(FULL_STEP) + delta;
    end else if (svc < 0) begin
      theta = theta - (32'(FULL_STEP) - delta);
      vc = -vc;
      svc = vc;
    end
    if (svc > int'(lim)) r.cur = lim[11:0];
    else if (svc < 0) r.cur = 12'd0;
    else r.cur = svc[11:0];
    r.phase = theta;
    return r;
  endfunction

  int src_gap = 0;

  // ---------------------------------------------------------------- driver
  always begin : tick_driver
    @(posedge clk_i);
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predicted_drive_q.push_back(advance_loop('{angle: in_ch.encoder_angle,
                                                 steps: in_ch.step_count}));
      if (predicted_drive_q[$].crossed) n_crossed++;
      if (predicted_drive_q[$].clamped) n_clamped++;
      ticks_done++;
      tick_offered = 1'b0;
    end
    @(negedge clk_i);
    if (rst_ni && !tick_offered) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 16);
        in_ch.valid = 1'b0;
      end else if (tick_q.size() > 0) begin
        tick_t t;
        t = tick_q.pop_front();
        in_ch.encoder_angle = t.angle;
        in_ch.step_count    = t.steps;
        in_ch.valid         = 1'b1;
        tick_offered        = 1'b1;
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int snk_gap = 0;
  int hold_left = 0;

  always begin : drive_monitor
    drive_t want;
    @(posedge clk_i);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (predicted_drive_q.size() == 0) begin
        $error("unexpected result transfer: phase_angle %0d current_ma %0d",
               out_ch.phase_angle, out_ch.current_ma);
        errors++;
      end else begin
        want = predicted_drive_q.pop_front();
        results_seen++;
        if (out_ch.phase_angle !== want.phase) begin
          $error("phase_angle: expected %0d, got %0d", want.phase, out_ch.phase_angle);
          errors++;
        end
        if (out_ch.current_ma !== want.cur) begin
          $error("current_ma: expected %0d, got %0d", want.cur, out_ch.current_ma);
          errors++;
        end
        if (out_ch.error_clamped !== want.clamped) begin
          $error("error_clamped: expected %0d, got %0d", want.clamped,
                 out_ch.error_clamped);
          errors++;
        end
        if (out_ch.revolution_crossed !== want.crossed) begin
          $error("revolution_crossed: expected %0d, got %0d", want.crossed,
                 out_ch.revolution_crossed);
          errors++;
        end
      end
    end
    @(negedge clk_i);
    if (rst_ni) begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 16);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               predicted_drive_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic push_tick(logic [13:0] angle, logic [31:0] steps);
    tick_q.push_back('{angle: angle, steps: steps});
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || tick_offered || predicted_drive_q.size() != 0);
  endtask

  // registers are only touched while the core is idle
  task automatic apply_settings();
    cfg_idx_e idx;
    idx = idx.first();
    for (int i = 0; i < idx.num(); i++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_idx_i   = idx;
      cfg_wdata_i = next_set[idx];
      reg_shadow[idx] = next_set[idx];
      idx = idx.next();
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_value(set_mode_e m, logic [31:0] lo,
                                             logic [31:0] hi);
    int unsigned r;
    if (m == SET_HIGH) return hi;
    if (m == SET_LOW) return lo;
    r = $urandom_range(0, 5);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r < 4) return lo + $urandom_range(0, (hi - lo) >> 4);
    return lo + $urandom_range(0, hi - lo);
  endfunction

  task automatic pick_settings(set_mode_e m);
    next_set[CFG_STEP_OFFSET]   = pick_value(m, 32'h8000_0000, 32'h7FFF_FFFF);
    next_set[CFG_MICROSTEP_DIV] = pick_value(m, 32'd1, 32'd511);
    next_set[CFG_GAIN_P]        = pick_value(m, 32'd0, 32'd4095);
    next_set[CFG_GAIN_I]        = pick_value(m, 32'd0, 32'd4095);
    next_set[CFG_GAIN_D]        = pick_value(m, 32'd0, 32'd4095);
    next_set[CFG_FILTER_A]      = pick_value(m, 32'd0, 32'd255);
    next_set[CFG_FILTER_B]      = pick_value(m, 32'd0, 32'd255);
    next_set[CFG_CURRENT_LIMIT] = pick_value(m, 32'd0, 32'd4095);
    if (m == SET_MIXED && $urandom_range(0, 7) == 0) next_set[CFG_MICROSTEP_DIV] = 32'd0;
  endtask

  // Encoder follows the commanded position with noise; each jump stays well
  // under half a turn so the unwrap stays in step. A glitch is one random
  // angle followed by the previous angle again, which undoes any wrap it did.
  task automatic queue_tracking(int n, logic [31:0] steps);
    int here, want, dp, vel, noise;
    here = int'(prev_pos);
    vel = $urandom_range(0, 64);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        push_tick(14'($urandom_range(0, 16383)), steps);
        push_tick(here[13:0], steps);
        i++;
      end else begin
        steps = steps + 32'($urandom_range(0, 2 * vel)) - 32'(vel);
        if ($urandom_range(0, 7) == 0) noise = int'($urandom_range(0, 8000)) - 4000;
        else noise = int'($urandom_range(0, 400)) - 200;
        want = int'(commanded_pos(reg_shadow[CFG_STEP_OFFSET],
                                  reg_shadow[CFG_MICROSTEP_DIV][8:0], steps)) + noise;
        dp = want - here;
        if (dp > 7000) dp = 7000;
        else if (dp < -7000) dp = -7000;
        here = here + dp;
        push_tick(here[13:0], steps);
      end
    end
  endtask

  task automatic queue_noise(int n);
    logic [13:0] a;
    logic [31:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: a = 14'd0;
        1: a = 14'h3FFF;
        default: a = 14'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 11))
        0: s = 32'h8000_0000;
        1: s = 32'h7FFF_FFFF;
        2: s = 32'd0;
        3: s = 32'hFFFF_FFFF;
        default: s = $urandom;
      endcase
      push_tick(a, s);
    end
  endtask

  initial begin : stimulus
    logic [31:0] steps0;
    set_mode_e   mode;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_STEP_OFFSET;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.encoder_angle = '0;
    in_ch.step_count    = '0;
    out_ch.ready        = 1'b0;
    foreach (reg_shadow[i]) reg_shadow[i] = '0;
    reg_shadow[CFG_MICROSTEP_DIV] = 32'd16;
    reg_shadow[CFG_CURRENT_LIMIT] = 32'd3300;
    prev_angle = '0;
    rev_cnt    = '0;
    prev_pos   = '0;
    integ      = '0;
    dfilt      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: all gains zero, so the PID sum is zero throughout
    push_tick(14'd0, 32'd0);
    push_tick(14'h3FFF, 32'h7FFF_FFFF);
    push_tick(14'd0, 32'h8000_0000);
    push_tick(14'd8192, 32'hFFFF_FFFF);
    push_tick(14'h3FFF, 32'd0);
    push_tick(14'd8191, 32'd1);
    push_tick(14'd0, 32'd100);
    push_tick(14'd5000, -32'sd100);
    wait_drain();

    // everything at the top, zero divisor, limit above the rated current
    next_set[CFG_STEP_OFFSET]   = 32'h7FFF_FFFF;
    next_set[CFG_MICROSTEP_DIV] = 32'd0;
    next_set[CFG_GAIN_P]        = 32'd4095;
    next_set[CFG_GAIN_I]        = 32'd4095;
    next_set[CFG_GAIN_D]        = 32'd4095;
    next_set[CFG_FILTER_A]      = 32'd255;
    next_set[CFG_FILTER_B]      = 32'd255;
    next_set[CFG_CURRENT_LIMIT] = 32'd4095;
    apply_settings();
    push_tick(14'd0, 32'h7FFF_FFFF);
    push_tick(14'h3FFF, 32'h8000_0000);
    push_tick(14'd100, 32'd12345);
    push_tick(14'd16000, -32'sd12345);
    push_tick(14'd0, 32'd0);
    push_tick(14'd8192, 32'd1);
    wait_drain();

    // divisor beyond a byte, most negative offset, zero current limit
    next_set[CFG_STEP_OFFSET]   = 32'h8000_0000;
    next_set[CFG_MICROSTEP_DIV] = 32'd511;
    next_set[CFG_GAIN_P]        = 32'd1;
    next_set[CFG_GAIN_I]        = 32'd4095;
    next_set[CFG_GAIN_D]        = 32'd0;
    next_set[CFG_FILTER_A]      = 32'd128;
    next_set[CFG_FILTER_B]      = 32'd8;
    next_set[CFG_CURRENT_LIMIT] = 32'd0;
    apply_settings();
    push_tick(14'h3FFF, 32'd0);
    push_tick(14'd0, 32'hFFFF_FFFF);
    push_tick(14'd1, 32'h7FFF_FFFF);
    push_tick(14'd9000, 32'h8000_0000);
    push_tick(14'd300, 32'd200);
    wait_drain();

    next_set[CFG_STEP_OFFSET]   = 32'd0;
    next_set[CFG_MICROSTEP_DIV] = 32'd1;
    next_set[CFG_GAIN_P]        = 32'd4095;
    next_set[CFG_GAIN_I]        = 32'd0;
    next_set[CFG_GAIN_D]        = 32'd1;
    next_set[CFG_FILTER_A]      = 32'd0;
    next_set[CFG_FILTER_B]      = 32'd255;
    next_set[CFG_CURRENT_LIMIT] = 32'd3300;
    apply_settings();
    push_tick(14'd0, 32'd2);
    push_tick(14'd1, 32'd3);
    push_tick(14'h3FFF, 32'd4);
    wait_drain();

    for (int k = 0; k < NUM_PHASES; k++) begin
      idle_en = (k < NUM_PHASES - 2) && (k != 4);
      mode = (k == 0) ? SET_HIGH : (k == 1) ? SET_LOW : SET_MIXED;
      pick_settings(mode);
      if (k == 3 || k == 8) begin
        apply_settings();
        queue_noise(PHASE_TICKS);
      end else begin
        // line the commanded position up with where the rotor is now
        if ($urandom_range(0, 3) == 0) steps0 = $urandom;
        else steps0 = 32'($urandom_range(0, 20000)) - 32'd10000;
        next_set[CFG_STEP_OFFSET] = prev_pos - commanded_pos(32'd0,
                                      next_set[CFG_MICROSTEP_DIV][8:0], steps0);
        apply_settings();
        // receiver stalls long enough for the core to back up its input
        if (k == 2) hold_out_req = 1'b1;
        queue_tracking(PHASE_TICKS, steps0);
      end
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Covered %0d control ticks over %0d register settings, %0d results checked.",
             ticks_done, NUM_PHASES + 4, results_seen);
    $display("Saw %0d revolution crossings and %0d clamped position errors.",
             n_crossed, n_clamped);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ stepper_position_pid_loop_core.f @@
src/stp_pkg.sv
src/stp_in_if.sv
src/stp_out_if.sv
src/stp_mul.sv
src/stp_sdiv.sv
src/stepper_position_pid_loop_core.sv
sim/tb_stepper_position_pid_loop_core.sv
